### hdl/ogfp_pkg.sv
// ogfp_pkg: shared types, fixed-point constants and table functions for the
// orthographic globe projection unit. No dependencies.
`timescale 1ns / 1ps
package ogfp_pkg;

    localparam int FRAC_BITS = 28;             // fraction bits of the Mercator inputs
    localparam int QB        = 30;             // internal fraction bits
    localparam int QW        = 32 + QB - FRAC_BITS;  // Q30 angle width
    localparam int TW        = 32;             // trig value width
    localparam int DIV_BITS  = 31;             // quotient bits of sin/cos division

    localparam logic signed [35:0] PI_Q      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q  = 36'sd6746518852;
    localparam longint QUARTER_PI_Q = 64'sd843314857;
    localparam longint LN2_Q        = 64'sd744261118;

    // latencies in register stages
    localparam int ALIGN_DLY   = 38;           // latitude path minus longitude path
    localparam int POST_STAGES = 6;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBE_RADIUS    = 3'd4;

    localparam logic [1:0] STATUS_VISIBLE    = 2'd0;
    localparam logic [1:0] STATUS_BEHIND     = 2'd1;
    localparam logic [1:0] STATUS_BAD_RADIUS = 2'd2;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } point_t;

    typedef struct packed {
        logic signed [27:0] screen_x;
        logic signed [27:0] screen_y;
        logic [1:0]         status;
    } result_t;

    function automatic int ogfp_lat_latency(input int n);
        return n + 42;
    endfunction

    function automatic int ogfp_latency(input int n);
        return 1 + ogfp_lat_latency(n) + POST_STAGES;
    endfunction

    // unsigned shift-subtract division, used only for table constants
    function automatic longint ogfp_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] r;
        logic [63:0] q;
        r = 64'd0;
        q = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return longint'(q);
    endfunction

    // atan(2^-i) in Q30 from its series, rounded
    function automatic longint ogfp_atan(input int i);
        longint sa;
        longint term;
        sa = 0;
        if (i == 0)
            return QUARTER_PI_Q;
        for (int k = 1; k * i <= 60; k++)
        begin
            term = ogfp_udiv(64'd1 << (60 - k * i), 64'(k));
            if ((k % 2) == 1)
                sa = ((k % 4) == 1) ? sa + term : sa - term;
        end
        return (sa + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // ln(1 + 2^-i) in Q30 from its series, rounded
    function automatic longint ogfp_lnp(input int i);
        longint sl;
        longint term;
        sl = 0;
        if (i == 0)
            return LN2_Q;
        for (int k = 1; k * i <= 60; k++)
        begin
            term = ogfp_udiv(64'd1 << (60 - k * i), 64'(k));
            sl = ((k % 2) == 1) ? sl + term : sl - term;
        end
        return (sl + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // CORDIC start value 1 / sqrt(prod(1 + 2^-2i)), Q30
    function automatic longint ogfp_gain(input int n);
        logic [63:0] p;
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        int nn;
        nn = (n > 60) ? 60 : n;
        p = 64'd1 << 60;
        for (int i = 0; i < nn; i++)
            p = p + (p >> (2 * i));
        rem = p;
        res = 64'd0;
        bit_v = 64'd1 << 62;
        for (int t = 0; t < 32; t++)
            if (bit_v > rem)
                bit_v = bit_v >> 2;
        for (int t = 0; t < 32; t++)
        begin
            if (bit_v != 64'd0)
            begin
                if (rem >= res + bit_v)
                begin
                    rem = rem - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else
                    res = res >> 1;
                bit_v = bit_v >> 2;
            end
        end
        return ogfp_udiv(64'd1 << 60, res);
    endfunction

endpackage

### hdl/ogfp_lat.sv
// ogfp_lat: latitude sine/cosine pipeline, sin = tanh y, cos = sech y,
// via shift-add exponential and two restoring dividers. Uses ogfp_pkg.
`timescale 1ns / 1ps
module ogfp_lat #(
    parameter int STAGES = 24
) (
    input  logic                           clk,
    input  logic signed [ogfp_pkg::QW-1:0] y_q,
    output logic signed [ogfp_pkg::TW-1:0] sin_q,
    output logic signed [ogfp_pkg::TW-1:0] cos_q
);
    import ogfp_pkg::*;

    localparam int N = STAGES;
    localparam int NEG_LEN = N + 41;

    logic [QW-1:0] rem_reg [0:5];
    logic [4:0]    k_reg   [0:5];
    logic          neg_reg [0:NEG_LEN-1];

    logic [30:0]   es_reg [0:N];
    logic [31:0]   ev_reg [0:N];
    logic [4:0]    ek_reg [0:N];

    logic [30:0]   e_sh_reg;
    logic [30:0]   e_mu_reg;
    logic [30:0]   e2_reg;

    logic [31:0]         dden_reg [0:DIV_BITS];
    logic [31:0]         drs_reg  [0:DIV_BITS];
    logic [31:0]         drc_reg  [0:DIV_BITS];
    logic [DIV_BITS-1:0] dqs_reg  [0:DIV_BITS];
    logic [DIV_BITS-1:0] dqc_reg  [0:DIV_BITS];
    logic                xs0_reg;

    logic [61:0] e2_next;
    logic [30:0] xs_next;

    // magnitude and sign
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= y_q[QW-1] ? QW'(-y_q) : QW'(y_q);
        k_reg[0]   <= 5'd0;
        neg_reg[0] <= y_q[QW-1];
    end

    genvar g;
    generate
        for (g = 1; g < NEG_LEN; g++)
        begin : g_neg
            always_ff @(posedge clk)
                neg_reg[g] <= neg_reg[g-1];
        end

        // k = |y| / ln2, one quotient bit a stage
        for (g = 0; g < 5; g++)
        begin : g_k
            localparam logic [QW-1:0] CMP = QW'(LN2_Q <<< (4 - g));
            always_ff @(posedge clk)
            begin
                if (rem_reg[g] >= CMP)
                begin
                    rem_reg[g+1] <= rem_reg[g] - CMP;
                    k_reg[g+1]   <= {k_reg[g][3:0], 1'b1};
                end
                else
                begin
                    rem_reg[g+1] <= rem_reg[g];
                    k_reg[g+1]   <= {k_reg[g][3:0], 1'b0};
                end
            end
        end

        for (g = 1; g <= N; g++)
        begin : g_exp
            localparam logic [30:0] LNP = 31'(ogfp_lnp(g));
            always_ff @(posedge clk)
            begin
                ek_reg[g] <= ek_reg[g-1];
                if (es_reg[g-1] >= LNP)
                begin
                    es_reg[g] <= es_reg[g-1] - LNP;
                    ev_reg[g] <= ev_reg[g-1] + (ev_reg[g-1] >> g);
                end
                else
                begin
                    es_reg[g] <= es_reg[g-1];
                    ev_reg[g] <= ev_reg[g-1];
                end
            end
        end

        // restoring division, quotient bit 30 down to 0
        for (g = 1; g <= DIV_BITS; g++)
        begin : g_div
            logic [32:0] ts;
            logic [32:0] tc;
            assign ts = {drs_reg[g-1], (g == 1) ? xs0_reg : 1'b0};
            assign tc = {drc_reg[g-1], 1'b0};
            always_ff @(posedge clk)
            begin
                dden_reg[g] <= dden_reg[g-1];
                if (ts >= {1'b0, dden_reg[g-1]})
                begin
                    drs_reg[g] <= 32'(ts - {1'b0, dden_reg[g-1]});
                    dqs_reg[g] <= {dqs_reg[g-1][DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    drs_reg[g] <= ts[31:0];
                    dqs_reg[g] <= {dqs_reg[g-1][DIV_BITS-2:0], 1'b0};
                end
                if (tc >= {1'b0, dden_reg[g-1]})
                begin
                    drc_reg[g] <= 32'(tc - {1'b0, dden_reg[g-1]});
                    dqc_reg[g] <= {dqc_reg[g-1][DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    drc_reg[g] <= tc[31:0];
                    dqc_reg[g] <= {dqc_reg[g-1][DIV_BITS-2:0], 1'b0};
                end
            end
        end
    endgenerate

    // s = ln2 - remainder, exponential starts at one
    always_ff @(posedge clk)
    begin
        es_reg[0] <= 31'(LN2_Q) - rem_reg[5][30:0];
        ev_reg[0] <= 32'd1 << QB;
        ek_reg[0] <= k_reg[5];
    end

    assign e2_next = 62'(e_sh_reg) * 62'(e_sh_reg);
    assign xs_next = (31'd1 << QB) - e2_reg;

    always_ff @(posedge clk)
    begin
        e_sh_reg <= 31'(ev_reg[N] >> ({1'b0, ek_reg[N]} + 6'd1));
        e_mu_reg <= e_sh_reg;
        e2_reg   <= e2_next[60:30];
        // numerators (1 - e^2) << 30 and 2e << 30 over 1 + e^2
        dden_reg[0] <= (32'd1 << QB) + {1'b0, e2_reg};
        drs_reg[0]  <= {2'b00, xs_next[30:1]};
        xs0_reg     <= xs_next[0];
        drc_reg[0]  <= {1'b0, e_mu_reg};
        dqs_reg[0]  <= '0;
        dqc_reg[0]  <= '0;
        sin_q <= neg_reg[NEG_LEN-1] ? -$signed({1'b0, dqs_reg[DIV_BITS]})
                                    : $signed({1'b0, dqs_reg[DIV_BITS]});
        cos_q <= $signed({1'b0, dqc_reg[DIV_BITS]});
    end

endmodule

### hdl/orthographic_globe_forward_projection_unit.sv
// Orthographic globe forward projection, top level: longitude wrap and CORDIC,
// two latitude pipelines (ogfp_lat), dot product and screen scaling. Uses ogfp_pkg.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------
//  item in   | start / busy         | point  (point_x, point_y)
//  result    | done strobe          | result (screen_x, screen_y, status)
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item is taken every cycle; busy stays low. The delay from an item to its
// result is set by the latitude path: exponential iterations plus a 31-stage
// restoring divider.
// rst_n clears the valid line and configuration; the viewport resets to 1024 x 768.
// Results are shown for one cycle under done; the receiver cannot stall.
`timescale 1ns / 1ps
module orthographic_globe_forward_projection_unit #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ogfp_pkg::point_t                  point,
    output logic                              done,
    output ogfp_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ogfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);
    import ogfp_pkg::*;

    localparam int N   = CORDIC_STAGES;
    localparam int TOT = ogfp_latency(N);
    localparam int CW  = 34;
    localparam int QSH = QB - FRAC_BITS;
    localparam logic signed [CW-1:0] GAIN = CW'(ogfp_gain(N));

    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic [14:0]        vp_w_reg;
    logic [14:0]        vp_h_reg;
    logic [23:0]        radius_reg;

    logic [TOT-1:0]     vld_reg;
    logic               accept;

    logic signed [QW-1:0] px_reg, py_reg, cx_reg, cy_reg;
    logic signed [QW-1:0] wp_reg, wc_reg;
    logic signed [QW-1:0] z_reg;

    logic signed [CW-1:0] ci_x_reg [0:N];
    logic signed [CW-1:0] ci_y_reg [0:N];
    logic signed [CW-1:0] ci_z_reg [0:N];
    logic                 ci_f_reg [0:N];

    logic signed [TW-1:0] dl_s_reg [0:ALIGN_DLY];
    logic signed [TW-1:0] dl_c_reg [0:ALIGN_DLY];

    logic signed [TW-1:0] sp, cp, sc, cc;

    logic signed [TW-1:0] m1_p1_reg, m1_p2_reg, m1_p3_reg, m1_p4_reg, m1_tx_reg, m1_cd_reg;
    logic signed [TW-1:0] m2_p1_reg, m2_p3_reg, m2_p5_reg, m2_p6_reg, m2_tx_reg;
    logic signed [TW-1:0] m3_tx_reg;
    logic signed [TW:0]   m3_ty_reg;
    logic                 m3_neg_reg, m4_neg_reg, m5_neg_reg;
    logic signed [57:0]   m4_ox_reg, m4_oy_reg;
    logic signed [27:0]   m5_ox_reg, m5_oy_reg;
    logic signed [TW:0]   vis_next;
    logic signed [57:0]   rnd_ox_next, rnd_oy_next;
    logic signed [29:0]   sx_next, sy_next;
    logic signed [QW+1:0] d_next;
    result_t              result_reg;

    function automatic logic signed [QW-1:0] wrap(input logic signed [QW+1:0] a);
        logic signed [QW+1:0] w;
        if (a >= PI_Q)
            w = a - TWO_PI_Q;
        else if (a < -PI_Q)
            w = a + TWO_PI_Q;
        else
            w = a;
        return w[QW-1:0];
    endfunction

    function automatic logic signed [TW-1:0] mulq(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic signed [63:0] p;
        p = a * b;
        return TW'(p >>> QB);
    endfunction

    function automatic logic signed [27:0] sat28(input logic signed [29:0] v);
        if (v > 30'sd134217727)
            return 28'sh7FFFFFF;
        if (v < -30'sd134217728)
            return 28'sh8000000;
        return v[27:0];
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            vp_w_reg     <= 15'd1024;
            vp_h_reg     <= 15'd768;
            radius_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CENTER_X:        center_x_reg <= cfg_data;
                REG_CENTER_Y:        center_y_reg <= cfg_data;
                REG_VIEWPORT_WIDTH:  vp_w_reg     <= cfg_data[14:0];
                REG_VIEWPORT_HEIGHT: vp_h_reg     <= cfg_data[14:0];
                REG_GLOBE_RADIUS:    radius_reg   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[TOT-2:0], accept};
    end

    // input stage, converted to Q30
    always_ff @(posedge clk)
    begin
        px_reg <= $signed({point.point_x, {QSH{1'b0}}});
        py_reg <= $signed({point.point_y, {QSH{1'b0}}});
        cx_reg <= $signed({center_x_reg, {QSH{1'b0}}});
        cy_reg <= $signed({center_y_reg, {QSH{1'b0}}});
    end

    assign d_next = (QW+2)'(wp_reg) - (QW+2)'(wc_reg);

    // longitude wrap, difference wrap, quadrant fold
    always_ff @(posedge clk)
    begin
        wp_reg <= wrap((QW+2)'(px_reg));
        wc_reg <= wrap((QW+2)'(cx_reg));
        z_reg  <= wrap(d_next);
        ci_x_reg[0] <= GAIN;
        ci_y_reg[0] <= '0;
        if ((QW+2)'(z_reg) > HALF_PI_Q)
        begin
            ci_z_reg[0] <= CW'((QW+2)'(z_reg) - PI_Q);
            ci_f_reg[0] <= 1'b1;
        end
        else if ((QW+2)'(z_reg) < -HALF_PI_Q)
        begin
            ci_z_reg[0] <= CW'((QW+2)'(z_reg) + PI_Q);
            ci_f_reg[0] <= 1'b1;
        end
        else
        begin
            ci_z_reg[0] <= CW'(z_reg);
            ci_f_reg[0] <= 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cordic
            localparam logic signed [CW-1:0] ATAN = CW'(ogfp_atan(g));
            always_ff @(posedge clk)
            begin
                ci_f_reg[g+1] <= ci_f_reg[g];
                if (ci_z_reg[g] >= 0)
                begin
                    ci_x_reg[g+1] <= ci_x_reg[g] - (ci_y_reg[g] >>> g);
                    ci_y_reg[g+1] <= ci_y_reg[g] + (ci_x_reg[g] >>> g);
                    ci_z_reg[g+1] <= ci_z_reg[g] - ATAN;
                end
                else
                begin
                    ci_x_reg[g+1] <= ci_x_reg[g] + (ci_y_reg[g] >>> g);
                    ci_y_reg[g+1] <= ci_y_reg[g] - (ci_x_reg[g] >>> g);
                    ci_z_reg[g+1] <= ci_z_reg[g] + ATAN;
                end
            end
        end

        // hold sin/cos of the longitude until the latitude values catch up
        for (g = 1; g <= ALIGN_DLY; g++)
        begin : g_align
            always_ff @(posedge clk)
            begin
                dl_s_reg[g] <= dl_s_reg[g-1];
                dl_c_reg[g] <= dl_c_reg[g-1];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        dl_s_reg[0] <= ci_f_reg[N] ? TW'(-ci_y_reg[N]) : TW'(ci_y_reg[N]);
        dl_c_reg[0] <= ci_f_reg[N] ? TW'(-ci_x_reg[N]) : TW'(ci_x_reg[N]);
    end

    ogfp_lat #(.STAGES(N)) u_lat_pt (
        .clk   (clk),
        .y_q   (py_reg),
        .sin_q (sp),
        .cos_q (cp)
    );

    ogfp_lat #(.STAGES(N)) u_lat_ctr (
        .clk   (clk),
        .y_q   (cy_reg),
        .sin_q (sc),
        .cos_q (cc)
    );

    assign vis_next    = (TW+1)'(m2_p1_reg) + (TW+1)'(m2_p5_reg);
    assign rnd_ox_next = m4_ox_reg + (58'sd1 <<< (QB - 1));
    assign rnd_oy_next = m4_oy_reg + (58'sd1 <<< (QB - 1));
    assign sx_next     = $signed({8'd0, vp_w_reg, 7'd0}) + 30'(m5_ox_reg);
    assign sy_next     = $signed({8'd0, vp_h_reg, 7'd0}) - 30'(m5_oy_reg);

    always_ff @(posedge clk)
    begin
        m1_p1_reg <= mulq(sc, sp);
        m1_p2_reg <= mulq(cc, cp);
        m1_p3_reg <= mulq(cc, sp);
        m1_p4_reg <= mulq(sc, cp);
        m1_tx_reg <= mulq(cp, dl_s_reg[ALIGN_DLY]);
        m1_cd_reg <= dl_c_reg[ALIGN_DLY];

        m2_p1_reg <= m1_p1_reg;
        m2_p3_reg <= m1_p3_reg;
        m2_tx_reg <= m1_tx_reg;
        m2_p5_reg <= mulq(m1_p2_reg, m1_cd_reg);
        m2_p6_reg <= mulq(m1_p4_reg, m1_cd_reg);

        m3_neg_reg <= vis_next[TW];
        m3_tx_reg  <= m2_tx_reg;
        m3_ty_reg  <= (TW+1)'(m2_p3_reg) - (TW+1)'(m2_p6_reg);

        m4_neg_reg <= m3_neg_reg;
        m4_ox_reg  <= $signed({1'b0, radius_reg}) * m3_tx_reg;
        m4_oy_reg  <= $signed({1'b0, radius_reg}) * m3_ty_reg;

        m5_neg_reg <= m4_neg_reg;
        m5_ox_reg  <= 28'(rnd_ox_next >>> QB);
        m5_oy_reg  <= 28'(rnd_oy_next >>> QB);

        if (radius_reg == '0)
        begin
            result_reg.screen_x <= '0;
            result_reg.screen_y <= '0;
            result_reg.status   <= STATUS_BAD_RADIUS;
        end
        else
        begin
            result_reg.screen_x <= sat28(sx_next);
            result_reg.screen_y <= sat28(sy_next);
            result_reg.status   <= m5_neg_reg ? STATUS_BEHIND : STATUS_VISIBLE;
        end
    end

    assign done   = vld_reg[TOT-1];
    assign result = result_reg;

endmodule

### hdl/ogfp_chk.sv
// ogfp_chk: port-level checks for the projection unit, bound to the top level.
// Uses ogfp_pkg for status codes and latency.
`timescale 1ns / 1ps
module ogfp_chk #(
    parameter int CORDIC_STAGES = 24
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input ogfp_pkg::result_t result
);
    import ogfp_pkg::*;

    localparam int LAT = ogfp_latency(CORDIC_STAGES);

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == STATUS_VISIBLE || result.status == STATUS_BEHIND ||
                  result.status == STATUS_BAD_RADIUS))
        else $error("undefined status code");

    a_bad_radius_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_BAD_RADIUS) |->
            (result.screen_x == '0 && result.screen_y == '0))
        else $error("invalid radius result carries coordinates");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without an item taken");

    a_item_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("item taken but no result");

endmodule

bind orthographic_globe_forward_projection_unit ogfp_chk #(
    .CORDIC_STAGES(CORDIC_STAGES)
) u_ogfp_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### sim/orthographic_globe_forward_projection_unit_test.sv
// Self-checking bench for orthographic_globe_forward_projection_unit: random and
// directed points under several view settings, results checked against a local
// fixed-point projection model. Depends on ogfp_pkg and the unit itself.
`timescale 1ns / 1ps

class projection_scoreboard;
    ogfp_pkg::result_t pending[$];
    int unsigned       n_points;
    int unsigned       n_checked;
    int unsigned       n_errors;
    int unsigned       n_behind;

    function void note_point(ogfp_pkg::result_t r);
        pending.push_back(r);
        n_points++;
    endfunction

    // returns 0 on mismatch or with nothing pending, 1 otherwise; caller prints
    function int check_result(ogfp_pkg::result_t got, output string msg);
        ogfp_pkg::result_t want;
        if (pending.size() == 0)
        begin
            msg = $sformatf("result with nothing pending: %h", got);
            n_errors++;
            return 0;
        end
        want = pending.pop_front();
        n_checked++;
        if (got.status == ogfp_pkg::STATUS_BEHIND)
            n_behind++;
        if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y
            || got.status !== want.status)
        begin
            msg = $sformatf("x %0d/%0d y %0d/%0d st %0d/%0d (got/want)",
                got.screen_x, want.screen_x, got.screen_y, want.screen_y,
                got.status, want.status);
            n_errors++;
            return 0;
        end
        return 1;
    endfunction
endclass

module orthographic_globe_forward_projection_unit_test;
    import ogfp_pkg::*;

    localparam int STAGES  = 24;
    localparam int LATENCY = STAGES + 49;
    localparam longint ONE_Q = longint'(1) <<< QB;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    point_t      point;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    orthographic_globe_forward_projection_unit #(.CORDIC_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    projection_scoreboard board;

    // view settings as the unit should hold them
    longint view_cx, view_cy, view_w, view_h, view_r;
    longint atan_q[0:60];
    longint lnp_q[0:60];
    longint gain_q;
    int     cfg_writes;
    int     n_reported;
    bit     dense;

    function automatic longint shr_floor(longint v, int s);
        return v >= 0 ? (v >>> s) : ~((~v) >>> s);
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return shr_floor(a * b, QB);
    endfunction

    function automatic longint wrap_pi(longint a);
        longint w;
        w = (a + PI_Q) % TWO_PI_Q;
        if (w < 0)
            w += TWO_PI_Q;
        return w - PI_Q;
    endfunction

    function automatic longint exp_minus(longint a);
        longint k, s, v;
        v = ONE_Q;
        if (a >= (longint'(32) <<< QB))
            return 0;
        k = a / LN2_Q;
        s = LN2_Q - (a - k * LN2_Q);
        for (int i = 1; i <= STAGES; i++)
            if (s >= lnp_q[i])
            begin
                s -= lnp_q[i];
                v += v >>> i;
            end
        return v >>> (k + 1);
    endfunction

    // sin and cos of the Gudermannian via tanh and sech
    function automatic void latitude_trig(input longint yq, output longint s,
                                          output longint c);
        longint a, e, e2, den, sv;
        a = yq < 0 ? -yq : yq;
        e = exp_minus(a);
        e2 = (e * e) >>> QB;
        den = ONE_Q + e2;
        sv = ((ONE_Q - e2) <<< QB) / den;
        c = ((2 * e) <<< QB) / den;
        s = yq < 0 ? -sv : sv;
    endfunction

    function automatic void longitude_trig(input longint z, output longint s,
                                           output longint c);
        longint x, y, nx;
        bit flip;
        x = gain_q;
        y = 0;
        flip = 0;
        if (z > HALF_PI_Q)
        begin
            z -= PI_Q;
            flip = 1;
        end
        else if (z < -HALF_PI_Q)
        begin
            z += PI_Q;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (z >= 0)
            begin
                nx = x - shr_floor(y, i);
                y += shr_floor(x, i);
                z -= atan_q[i];
            end
            else
            begin
                nx = x + shr_floor(y, i);
                y -= shr_floor(x, i);
                z += atan_q[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint clamp28(longint v);
        if (v > 134217727)
            return 134217727;
        if (v < -134217728)
            return -134217728;
        return v;
    endfunction

    function automatic result_t project_point(point_t p);
        result_t r;
        longint sc, cc, sp, cp, sd, cd, vis, tx, ty, ox, oy, dl;
        if (view_r == 0)
        begin
            r.screen_x = '0;
            r.screen_y = '0;
            r.status = STATUS_BAD_RADIUS;
            return r;
        end
        latitude_trig(view_cy <<< (QB - FRAC_BITS), sc, cc);
        latitude_trig(longint'(p.point_y) <<< (QB - FRAC_BITS), sp, cp);
        dl = wrap_pi(wrap_pi(longint'(p.point_x) <<< (QB - FRAC_BITS))
                     - wrap_pi(view_cx <<< (QB - FRAC_BITS)));
        longitude_trig(dl, sd, cd);
        vis = mul_q30(sc, sp) + mul_q30(mul_q30(cc, cp), cd);
        tx = mul_q30(cp, sd);
        ty = mul_q30(cc, sp) - mul_q30(mul_q30(sc, cp), cd);
        ox = shr_floor(view_r * tx + (longint'(1) <<< (QB - 1)), QB);
        oy = shr_floor(view_r * ty + (longint'(1) <<< (QB - 1)), QB);
        r.screen_x = 28'(clamp28(view_w * 128 + ox));
        r.screen_y = 28'(clamp28(view_h * 128 - oy));
        r.status = vis >= 0 ? STATUS_VISIBLE : STATUS_BEHIND;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        n_reported++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("FAIL orthographic_globe_forward_projection_unit");
        $finish;
    end

    // result side: every strobe is one item
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && done)
            if (!board.check_result(result, msg))
                report_mismatch(msg);
    end

    task automatic idle_gap();
        if (!dense)
            while ($urandom_range(99) < 26)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_CENTER_X:        view_cx = longint'(signed'(val));
            REG_CENTER_Y:        view_cy = longint'(signed'(val));
            REG_VIEWPORT_WIDTH:  view_w = val[14:0];
            REG_VIEWPORT_HEIGHT: view_h = val[14:0];
            REG_GLOBE_RADIUS:    view_r = val[23:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic send_point(input logic [31:0] px, input logic [31:0] py);
        point_t p;
        idle_gap();
        p.point_x = px;
        p.point_y = py;
        start <= 1'b1;
        point <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_point(project_point(p));
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic set_view(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] r);
        drain();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_VIEWPORT_WIDTH, w);
        write_reg(REG_VIEWPORT_HEIGHT, h);
        write_reg(REG_GLOBE_RADIUS, r);
        cfg_valid <= 1'b0;
    endtask

    // mostly points within a few radians, sometimes any 32-bit value or -1, 0, 1 plus 0 or 2^31
    function automatic logic [31:0] some_coord();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'($urandom_range(2)) - 32'sd1 + 32'h8000_0000 * $urandom_range(1);
            default: return 32'(signed'($urandom_range(32'h6000_0000)) - 32'sh3000_0000);
        endcase
    endfunction

    initial
    begin
        board = new();
        for (int i = 0; i <= 60; i++)
        begin
            atan_q[i] = ogfp_atan(i);
            lnp_q[i] = ogfp_lnp(i);
        end
        gain_q = ogfp_gain(STAGES);
        view_cx = 0;
        view_cy = 0;
        view_w = 1024;
        view_h = 768;
        view_r = 0;
        cfg_writes = 0;
        n_reported = 0;
        dense = 0;
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset view: radius zero gives the invalid status
        send_point(32'h1000_0000, 32'h0800_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);

        set_view(32'h0, 32'h0, 32'd1024, 32'd768, 32'd256 * 200);
        send_point(32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        send_point(32'h3243_F6A8, 32'h0);     // about +pi
        send_point(32'hCDBC_0958, 32'h0);     // about -pi
        send_point(32'h1921_FB54, 32'h0);     // quarter turn
        send_point(32'hE6DE_04AC, 32'h1000_0000);
        send_point(32'h0, 32'h4000_0000);     // far north
        send_point(32'h0, 32'hC000_0000);
        send_point(32'h5555_5555, 32'hAAAA_AAAA);
        send_point(32'hAAAA_AAAA, 32'h5555_5555);

        // largest radius and viewport the registers hold
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF, 32'h7FFF, 32'hFF_FFFF);
        send_point(32'h0, 32'h0);
        send_point(32'h3243_F6A8, 32'h8000_0000);
        send_point(32'h1921_FB54, 32'h0);
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        send_point(32'h0, 32'h0);
        send_point(32'h1921_FB54, 32'h1000_0000);

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                set_view(32'h0, 32'h0, 32'd800, 32'd600, 32'd0);
            else
                set_view(some_coord(), some_coord(), $urandom_range(1, 16384),
                         $urandom_range(1, 16384),
                         ph == 2 ? 32'hFF_FFFF : $urandom_range(1, 32'h10_0000));
            dense = (ph == 3);
            for (int i = 0; i < 250; i++)
                send_point(some_coord(), some_coord());
        end
        dense = 0;
        drain();

        $display("%0d points over %0d register writes, %0d results checked (%0d behind)",
                 board.n_points, cfg_writes, board.n_checked, board.n_behind);
        if (board.n_errors == 0 && n_reported == 0)
            $display("PASS orthographic_globe_forward_projection_unit");
        else
            $display("FAIL orthographic_globe_forward_projection_unit");
        $finish;
    end
endmodule

### filelist.f
hdl/ogfp_pkg.sv
hdl/ogfp_lat.sv
hdl/orthographic_globe_forward_projection_unit.sv
hdl/ogfp_chk.sv
sim/orthographic_globe_forward_projection_unit_test.sv
